[design/rtc_date_to_epoch_seconds_unit_assert.svh]
// ----------------------------------------------------------------------------
// RTC date to epoch seconds: assertion macros
// Concurrent checks clocked on clk; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef RTC_DATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define RTC_DATE_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that is off while reset is asserted
`define RTCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that holds at every edge, reset included
`define RTCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTCE_ASSERT(lbl, prop, msg)
`define RTCE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/rtce_pkg.sv]
// ----------------------------------------------------------------------------
// RTC date to epoch seconds: package
// Register indexes, calendar constants and field decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rtce_pkg;

    typedef enum logic [0:0] {
        CFG_FIELDS_ARE_BCD = 1'b0,
        CFG_CENTURY_OFFSET = 1'b1
    } cfg_index_t;

    localparam logic [31:0] SecsPerDay  = 32'd86400;
    localparam logic [31:0] SecsPerYear = 32'd31536000;

    localparam logic        BcdReset     = 1'b1;
    localparam logic [7:0]  CenturyReset = 8'd100;

    // Years since 1900 below this value lie before the epoch
    localparam logic [8:0]  EpochYear    = 9'd70;

    // Packed BCD byte to binary: low nibble plus ten times high nibble
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        begin
            hi = {4'd0, b[7:4]};
            return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
        end
    endfunction

    // Days before the first of a month, month given zero-based
    function automatic logic [8:0] days_before_month(input logic [3:0] prior);
        logic [8:0] d;
        begin
            case (prior)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

[design/rtc_date_to_epoch_seconds_unit.sv]
// Pipeline: four register stages; an accepted date passes through stage 1,
// stage 2, stage 3 and the output register before m_tvalid rises.
// Throughput: one date per cycle unless m_tready stalls the output; each stage
// advances on its own, so a stall only holds the stages behind a full one.
// Reset: clears all stage valid bits, sets fields_are_bcd to 1 and
// century_offset to 100.
// ----------------------------------------------------------------------------
// RTC date to epoch seconds unit
// Decodes raw clock fields (BCD or binary) and forms POSIX epoch seconds.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtc_date_to_epoch_seconds_unit_assert.svh"

module rtc_date_to_epoch_seconds_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // Input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // s_tdata: seconds_raw[7:0], minutes_raw[15:8], hours_raw[23:16],
    //          mday_raw[31:24], month_raw[39:32], year_raw[47:40]
    input  wire logic [47:0] s_tdata,
    // Output stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: epoch_seconds[31:0]
    output      logic [31:0] m_tdata,
    // m_tuser: invalid[0]
    output      logic [0:0]  m_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       bcd_reg, bcd_next;
    logic [7:0] century_reg, century_next;

    always_comb
    begin
        bcd_next     = bcd_reg;
        century_next = century_reg;
        if (cfg_we)
        begin
            case (rtce_pkg::cfg_index_t'(cfg_addr))
                rtce_pkg::CFG_FIELDS_ARE_BCD: bcd_next     = cfg_wdata[0];
                rtce_pkg::CFG_CENTURY_OFFSET: century_next = cfg_wdata;
                default:                      bcd_next     = bcd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg     <= rtce_pkg::BcdReset;
            century_reg <= rtce_pkg::CenturyReset;
        end
        else
        begin
            bcd_reg     <= bcd_next;
            century_reg <= century_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic v1_next, v2_next, v3_next, vo_next;
    logic ld1, ld2, ld3, ldo;

    assign ldo      = !vo_reg || m_tready;
    assign ld3      = !v3_reg || ldo;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;

    always_comb
    begin
        v1_next = ld1 ? s_tvalid : v1_reg;
        v2_next = ld2 ? v1_reg   : v2_reg;
        v3_next = ld3 ? v2_reg   : v3_reg;
        vo_next = ldo ? v3_reg   : vo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: field decode and years since 1900
    // ------------------------------------------------------------------
    logic [7:0] sec_next, min_next, hour_next, mday_next, mon_next, yr_next;
    logic [8:0] y_next;
    logic [7:0] sec_reg, min_reg, hour_reg, mday_reg, mon_reg;
    logic [8:0] y_reg;

    always_comb
    begin
        if (bcd_reg)
        begin
            sec_next  = rtce_pkg::bcd_decode(s_tdata[7:0]);
            min_next  = rtce_pkg::bcd_decode(s_tdata[15:8]);
            // drop the 12-hour PM flag in bit 7
            hour_next = rtce_pkg::bcd_decode({1'b0, s_tdata[22:16]});
            mday_next = rtce_pkg::bcd_decode(s_tdata[31:24]);
            mon_next  = rtce_pkg::bcd_decode(s_tdata[39:32]);
            yr_next   = rtce_pkg::bcd_decode(s_tdata[47:40]);
        end
        else
        begin
            sec_next  = s_tdata[7:0];
            min_next  = s_tdata[15:8];
            hour_next = s_tdata[23:16];
            mday_next = s_tdata[31:24];
            mon_next  = s_tdata[39:32];
            yr_next   = s_tdata[47:40];
        end
        y_next = {1'b0, century_reg} + {1'b0, yr_next};
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && s_tvalid)
        begin
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
            mday_reg <= mday_next;
            mon_reg  <= mon_next;
            y_reg    <= y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: day of year, time of day, leap-day count, year offset
    // ------------------------------------------------------------------
    logic [3:0]         prior;
    logic               leap;
    logic [8:0]         ym69;
    logic [7:0]         c100, c400;
    logic signed [10:0] yday_next, yday_reg;
    logic [19:0]        hms_next, hms_reg;
    logic [7:0]         lday_next, lday_reg;
    logic [8:0]         y70_next, y70_reg;
    logic               inv2_next, inv2_reg;

    always_comb
    begin
        if (mon_reg == 8'd0)
            prior = 4'd0;
        else if (mon_reg > 8'd12)
            prior = 4'd11;
        else
            prior = 4'(mon_reg - 8'd1);

        // full year is 1900 + y; of the century years 2100, 2200 and 2300 do not leap
        leap = (y_reg[1:0] == 2'd0)
            && !(y_reg == 9'd200 || y_reg == 9'd300 || y_reg == 9'd400);

        yday_next = $signed({2'b00, rtce_pkg::days_before_month(prior)})
                  + $signed({10'd0, (prior >= 4'd2) && leap})
                  + $signed({3'b000, mday_reg})
                  - 11'sd1;

        hms_next = {12'd0, sec_reg}
                 + 20'({12'd0, min_reg} * 20'd60)
                 + 20'({12'd0, hour_reg} * 20'd3600);

        // (y-69)/4 - (y-1)/100 + (y+299)/400 over the valid range of y
        ym69 = y_reg - 9'd69;
        c100 = {7'd0, y_reg >= 9'd101} + {7'd0, y_reg >= 9'd201}
             + {7'd0, y_reg >= 9'd301} + {7'd0, y_reg >= 9'd401}
             + {7'd0, y_reg >= 9'd501};
        c400 = {7'd0, y_reg >= 9'd101} + {7'd0, y_reg >= 9'd501};
        lday_next = {1'b0, ym69[8:2]} - c100 + c400;

        y70_next  = y_reg - rtce_pkg::EpochYear;
        inv2_next = y_reg < rtce_pkg::EpochYear;
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            yday_reg <= yday_next;
            hms_reg  <= hms_next;
            lday_reg <= lday_next;
            y70_reg  <= y70_next;
            inv2_reg <= inv2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: day and year products, mod 2^32
    // ------------------------------------------------------------------
    logic signed [11:0] days;
    logic [31:0]        dsec_next, dsec_reg;
    logic [31:0]        ysec_next, ysec_reg;
    logic [19:0]        hms3_reg;
    logic               inv3_reg;

    always_comb
    begin
        days      = 12'(yday_reg) + $signed({4'd0, lday_reg});
        // sign-extend so a day before the first wraps like the 32-bit sum
        dsec_next = 32'(32'(days) * rtce_pkg::SecsPerDay);
        ysec_next = 32'({23'd0, y70_reg} * rtce_pkg::SecsPerYear);
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            dsec_reg <= dsec_next;
            ysec_reg <= ysec_next;
            hms3_reg <= hms_reg;
            inv3_reg <= inv2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final sum into the output register
    // ------------------------------------------------------------------
    logic [31:0] epoch_next, epoch_reg;
    logic        inv_reg;

    always_comb
    begin
        if (inv3_reg)
            epoch_next = 32'd0;
        else
            epoch_next = {12'd0, hms3_reg} + dsec_reg + ysec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ldo && v3_reg)
        begin
            epoch_reg <= epoch_next;
            inv_reg   <= inv3_reg;
        end
    end

    assign m_tvalid   = vo_reg;
    assign m_tdata    = epoch_reg;
    assign m_tuser[0] = inv_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RTCE_ASSERT_ALWAYS(a_invalid_zero,
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0),
        "pre-epoch result carries nonzero seconds")
    `RTCE_ASSERT(a_accept_fills_s1,
        (s_tvalid && s_tready) |=> v1_reg,
        "accepted transaction did not reach stage 1")
    `RTCE_ASSERT(a_empty_out_ready,
        !vo_reg |-> s_tready,
        "input stalled while the output stage is empty")
    `RTCE_ASSERT(a_s3_hold,
        (v3_reg && vo_reg && !m_tready) |=> (v3_reg && $stable(dsec_reg)),
        "stage 3 lost or changed data under stall")
    `RTCE_ASSERT(a_s2_advance,
        (v2_reg && ld3) |=> v3_reg,
        "stage 2 item did not advance into stage 3")

endmodule

`default_nettype wire
